[rtl/qre_pkg.sv]
// Shared types and constants for the quadratic evaluate / root block.
// No dependencies; used by every module in rtl/.
package qre_pkg;

   // Field and datapath widths (sized for FRAC_BITS up to 24)
   localparam int WORD_W    = 32;
   localparam int P_W       = 66;   // a*x + b*2^F, exact
   localparam int ACC_W     = 100;  // (a*x + b*2^F)*x + c*2^2F + round
   localparam int DIGIT_W   = 8;
   localparam int N_CELLS   = WORD_W / DIGIT_W;
   localparam int DISC_W    = 67;   // b*b - 4ac
   localparam int SQ_N_W    = 116;  // radicand D * 2^2F
   localparam int SQ_R_W    = SQ_N_W / 2;
   localparam int SQ_REM_W  = SQ_R_W + 4;
   localparam int NUM_W     = 64;
   localparam int DIV_N_W   = 62;
   localparam int DIV_D_W   = 34;
   localparam int CNT_W     = 7;
   localparam int CSR_IDX_W = 2;
   localparam int REQ_W     = 32;
   localparam int RSP_W     = 72;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_C = 2'd2;

   // Root classes
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_ONE   = 2'd1;
   localparam logic [1:0] KIND_TWO   = 2'd2;
   localparam logic [1:0] KIND_DEGEN = 2'd3;

   // Data carried from cell to cell
   typedef struct packed {
      logic [P_W-1:0]    p;
      logic [WORD_W-1:0] x;
      logic [ACC_W-1:0]  acc;
   } qre_lane_type;

   // Root sequencer status
   typedef struct packed {
      logic              busy;
      logic [1:0]        kind;
      logic [WORD_W-1:0] root;
   } qre_root_type;

endpackage

[rtl/qre_cell.sv]
// One multiply-accumulate cell of the evaluation chain: adds P * (one 8-bit
// digit of x) into the running sum. Depends on qre_pkg.
module qre_cell #(
   parameter int DIGIT_POS = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   input  qre_pkg::qre_lane_type up_lane,
   output logic                  up_ready,
   output logic                  down_valid,
   output qre_pkg::qre_lane_type down_lane,
   input  logic                  down_ready
);
   localparam int LSB    = DIGIT_POS * qre_pkg::DIGIT_W;
   localparam int MSB    = LSB + qre_pkg::DIGIT_W - 1;
   localparam int PROD_W = qre_pkg::P_W + qre_pkg::DIGIT_W + 1;

   logic                        valid_ff;
   qre_pkg::qre_lane_type       lane_ff;
   qre_pkg::qre_lane_type       lane_in;
   logic signed [qre_pkg::DIGIT_W:0] digit;
   logic signed [PROD_W-1:0]         prod;
   logic signed [qre_pkg::ACC_W-1:0] term;

   // top digit carries the sign of x, the others are unsigned
   assign digit = (DIGIT_POS == qre_pkg::N_CELLS - 1)
                ? $signed({up_lane.x[MSB], up_lane.x[MSB:LSB]})
                : $signed({1'b0, up_lane.x[MSB:LSB]});
   assign prod  = $signed(up_lane.p) * digit;
   assign term  = $signed({{(qre_pkg::ACC_W-PROD_W){prod[PROD_W-1]}}, prod}) <<< LSB;

   always_comb begin
      lane_in     = up_lane;
      lane_in.acc = up_lane.acc + term;
   end

   assign up_ready   = !valid_ff || down_ready;
   assign down_valid = valid_ff;
   assign down_lane  = lane_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         lane_ff <= lane_in;
      end
   end
endmodule

[rtl/qre_root.sv]
// Root sequencer: discriminant, bit-serial square root and restoring divide,
// rerun after every coefficient write. Depends on qre_pkg.
module qre_root #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [qre_pkg::WORD_W-1:0]  coef_a,
   input  logic [qre_pkg::WORD_W-1:0]  coef_b,
   input  logic [qre_pkg::WORD_W-1:0]  coef_c,
   output qre_pkg::qre_root_type       status
);
   localparam int W = qre_pkg::WORD_W;
   localparam logic [qre_pkg::CNT_W-1:0] SQ_LAST  = qre_pkg::CNT_W'(qre_pkg::SQ_R_W - 1);
   localparam logic [qre_pkg::CNT_W-1:0] DIV_LAST = qre_pkg::CNT_W'(qre_pkg::DIV_N_W - 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL_BB, ST_MUL_AC, ST_CLASS, ST_SQRT,
      ST_NUM, ST_DIV_SET, ST_DIV, ST_DONE
   } state_type;

   state_type                          state_ff;
   logic [qre_pkg::CNT_W-1:0]          cnt_ff;
   logic [1:0]                         kind_ff, kind_pend_ff;
   logic [W-1:0]                       root_ff;
   logic signed [2*W-1:0]              bb_ff, ac_ff;
   logic [qre_pkg::SQ_N_W-1:0]         sq_n_ff;
   logic [qre_pkg::SQ_REM_W-1:0]       sq_rem_ff;
   logic [qre_pkg::SQ_R_W-1:0]         sq_root_ff;
   logic signed [qre_pkg::NUM_W-1:0]   num_ff;
   logic [qre_pkg::DIV_N_W-1:0]        div_n_ff;
   logic [qre_pkg::DIV_D_W-1:0]        div_d_ff, div_rem_ff;
   logic                               neg_ff;

   logic signed [qre_pkg::DISC_W-1:0]  disc;
   logic [qre_pkg::SQ_REM_W-1:0]       sq_rem_sh, sq_trial;
   logic [qre_pkg::DIV_D_W:0]          div_rem_sh;
   logic                               div_take;
   logic [W:0]                         a_mag;
   logic signed [qre_pkg::NUM_W-1:0]   b_shift, s_ext, num_in;
   logic [qre_pkg::NUM_W-1:0]          num_mag;
   logic signed [qre_pkg::DIV_N_W:0]   qv;
   logic                               q_fits;
   logic [W-1:0]                       root_sat;

   assign disc = $signed({{(qre_pkg::DISC_W-2*W){bb_ff[2*W-1]}}, bb_ff})
               - ($signed({{(qre_pkg::DISC_W-2*W){ac_ff[2*W-1]}}, ac_ff}) <<< 2);

   assign sq_rem_sh = {sq_rem_ff[qre_pkg::SQ_REM_W-3:0], sq_n_ff[qre_pkg::SQ_N_W-1 -: 2]};
   assign sq_trial  = {2'b00, sq_root_ff, 2'b01};

   assign div_rem_sh = {div_rem_ff, div_n_ff[qre_pkg::DIV_N_W-1]};
   assign div_take   = div_rem_sh >= {1'b0, div_d_ff};

   assign a_mag   = coef_a[W-1] ? (W+1)'(-$signed({coef_a[W-1], coef_a}))
                                : {1'b0, coef_a};
   assign b_shift = $signed({{(qre_pkg::NUM_W-W){coef_b[W-1]}}, coef_b}) <<< FRAC_BITS;
   assign s_ext   = $signed({{(qre_pkg::NUM_W-qre_pkg::SQ_R_W){1'b0}}, sq_root_ff});
   assign num_in  = coef_a[W-1] ? (-b_shift - s_ext) : (-b_shift + s_ext);
   assign num_mag = num_ff[qre_pkg::NUM_W-1] ? qre_pkg::NUM_W'(-num_ff) : num_ff;

   // signed quotient, then clamp to 32 bits
   assign qv       = neg_ff ? -$signed({1'b0, div_n_ff}) : $signed({1'b0, div_n_ff});
   assign q_fits   = (&qv[qre_pkg::DIV_N_W:W-1]) || !(|qv[qre_pkg::DIV_N_W:W-1]);
   assign root_sat = q_fits ? qv[W-1:0]
                   : (qv[qre_pkg::DIV_N_W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});

   assign status.busy = (state_ff != ST_IDLE);
   assign status.kind = kind_ff;
   assign status.root = root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= qre_pkg::KIND_DEGEN;
         root_ff  <= '0;
      end else if (start) begin
         state_ff <= ST_MUL_BB;
      end else begin
         case (state_ff)
            ST_IDLE: begin
            end
            ST_MUL_BB: begin
               bb_ff    <= $signed(coef_b) * $signed(coef_b);
               state_ff <= ST_MUL_AC;
            end
            ST_MUL_AC: begin
               ac_ff    <= $signed(coef_a) * $signed(coef_c);
               state_ff <= ST_CLASS;
            end
            ST_CLASS: begin
               sq_rem_ff  <= '0;
               sq_root_ff <= '0;
               cnt_ff     <= SQ_LAST;
               sq_n_ff    <= {{(qre_pkg::SQ_N_W-qre_pkg::DISC_W){1'b0}}, disc}
                             << (2*FRAC_BITS);
               if (coef_a == '0) begin
                  kind_ff  <= qre_pkg::KIND_DEGEN;
                  root_ff  <= '0;
                  state_ff <= ST_IDLE;
               end else if (disc[qre_pkg::DISC_W-1]) begin
                  kind_ff  <= qre_pkg::KIND_NONE;
                  root_ff  <= '0;
                  state_ff <= ST_IDLE;
               end else if (disc == '0) begin
                  kind_pend_ff <= qre_pkg::KIND_ONE;
                  state_ff     <= ST_NUM;
               end else begin
                  kind_pend_ff <= qre_pkg::KIND_TWO;
                  state_ff     <= ST_SQRT;
               end
            end
            ST_SQRT: begin
               sq_n_ff <= {sq_n_ff[qre_pkg::SQ_N_W-3:0], 2'b00};
               if (sq_rem_sh >= sq_trial) begin
                  sq_rem_ff  <= sq_rem_sh - sq_trial;
                  sq_root_ff <= {sq_root_ff[qre_pkg::SQ_R_W-2:0], 1'b1};
               end else begin
                  sq_rem_ff  <= sq_rem_sh;
                  sq_root_ff <= {sq_root_ff[qre_pkg::SQ_R_W-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_ff <= ST_NUM;
               end
            end
            ST_NUM: begin
               num_ff   <= num_in;
               state_ff <= ST_DIV_SET;
            end
            ST_DIV_SET: begin
               // (|num| + |a|) / (2|a|): half away from zero
               div_n_ff   <= num_mag[qre_pkg::DIV_N_W-1:0]
                           + {{(qre_pkg::DIV_N_W-W-1){1'b0}}, a_mag};
               div_d_ff   <= {a_mag, 1'b0};
               div_rem_ff <= '0;
               neg_ff     <= num_ff[qre_pkg::NUM_W-1] != coef_a[W-1];
               cnt_ff     <= DIV_LAST;
               state_ff   <= ST_DIV;
            end
            ST_DIV: begin
               div_rem_ff <= div_take
                           ? qre_pkg::DIV_D_W'(div_rem_sh - {1'b0, div_d_ff})
                           : div_rem_sh[qre_pkg::DIV_D_W-1:0];
               div_n_ff   <= {div_n_ff[qre_pkg::DIV_N_W-2:0], div_take};
               cnt_ff     <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               kind_ff  <= kind_pend_ff;
               root_ff  <= root_sat;
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end
endmodule

[rtl/quadratic_root_and_evaluate_top.sv]
// Top level of the quadratic evaluator / root finder.
// Depends on qre_pkg, qre_cell and qre_root.
//
// Evaluates y = a*x*x + b*x + c in signed fixed point (FRAC_BITS fraction
// bits) for every x transfer and returns it rounded half up and clamped to
// 32 bits, with an overflow flag, together with the root class and the
// largest real root of the current coefficients. Evaluation runs through a
// pipeline: one x register, a stage forming a*x, a stage forming
// a*x + b*2^F, a row of four cells that each fold one byte of x into the
// product (x*(a*x + b*2^F) + c*2^2F), and an output register. One transfer
// is taken per cycle unless rsp_tready stalls the pipeline or the roots are
// being recomputed. The roots depend only on the coefficients, so a sequencer
// recomputes them after each coefficient write: two 32x32 products, then for
// real roots a 58-step bit-serial square root (none for a double root) and a
// 62-step restoring divide. During that time req_tready is low. After reset
// the coefficients are zero and the root status (degenerate) is ready at once.
module quadratic_root_and_evaluate_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // input stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [qre_pkg::REQ_W-1:0]     req_tdata,   // [31:0] x_value
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [qre_pkg::RSP_W-1:0]     rsp_tdata,   // [31:0] y_value, [32] y_overflow,
                                                      // [34:33] root_kind,
                                                      // [66:35] largest_root, rest 0
   // coefficient writes
   input  logic                          csr_wr_en,
   input  logic [qre_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [qre_pkg::WORD_W-1:0]    csr_wdata
);
   localparam int W  = qre_pkg::WORD_W;
   localparam int AW = qre_pkg::ACC_W;
   localparam int NC = qre_pkg::N_CELLS;

   // coefficient registers
   logic [W-1:0] coef_a_ff, coef_b_ff, coef_c_ff;
   logic         csr_hit;

   assign csr_hit = csr_wr_en && (csr_index == qre_pkg::CSR_COEF_A ||
                                  csr_index == qre_pkg::CSR_COEF_B ||
                                  csr_index == qre_pkg::CSR_COEF_C);

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff <= '0;
         coef_b_ff <= '0;
         coef_c_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            qre_pkg::CSR_COEF_A: coef_a_ff <= csr_wdata;
            qre_pkg::CSR_COEF_B: coef_b_ff <= csr_wdata;
            qre_pkg::CSR_COEF_C: coef_c_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // root sequencer
   qre_pkg::qre_root_type root_status;

   qre_root #(.FRAC_BITS(FRAC_BITS)) u_root (
      .clock  (clock),
      .reset  (reset),
      .start  (csr_hit),
      .coef_a (coef_a_ff),
      .coef_b (coef_b_ff),
      .coef_c (coef_c_ff),
      .status (root_status)
   );

   // front stages: x, a*x, a*x + b*2^F
   logic                  v0_ff, v1_ff, v2_ff;
   logic [W-1:0]          x0_ff, x1_ff;
   logic signed [2*W-1:0] ax1_ff;
   qre_pkg::qre_lane_type lane2_ff, lane2_in;
   logic                  rdy0, rdy1, rdy2;

   // per-cell links; index NC is the output side
   logic                  cell_v   [NC+1];
   logic                  cell_rdy [NC+1];
   qre_pkg::qre_lane_type cell_lane[NC+1];

   logic                  out_v_ff, out_rdy;

   assign out_rdy    = !out_v_ff || rsp_tready;
   assign rdy2       = !v2_ff || cell_rdy[0];
   assign rdy1       = !v1_ff || rdy2;
   assign rdy0       = !v0_ff || rdy1;
   assign req_tready = rdy0 && !root_status.busy;

   always_comb begin
      lane2_in.x   = x1_ff;
      lane2_in.p   = qre_pkg::P_W'($signed({{(qre_pkg::P_W-2*W){ax1_ff[2*W-1]}}, ax1_ff})
                   + ($signed({{(qre_pkg::P_W-W){coef_b_ff[W-1]}}, coef_b_ff}) <<< FRAC_BITS));
      // c*2^2F plus the rounding half
      lane2_in.acc = ($signed({{(AW-W){coef_c_ff[W-1]}}, coef_c_ff}) <<< (2*FRAC_BITS))
                   + (AW'(1) << (2*FRAC_BITS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (rdy0) v0_ff <= req_tvalid && req_tready;
         if (rdy1) v1_ff <= v0_ff;
         if (rdy2) v2_ff <= v1_ff;
      end
      if (req_tvalid && req_tready) begin
         x0_ff <= req_tdata[W-1:0];
      end
      if (rdy1 && v0_ff) begin
         ax1_ff <= $signed(coef_a_ff) * $signed(x0_ff);
         x1_ff  <= x0_ff;
      end
      if (rdy2 && v1_ff) begin
         lane2_ff <= lane2_in;
      end
   end

   assign cell_v[0]    = v2_ff;
   assign cell_lane[0] = lane2_ff;
   assign cell_rdy[NC] = out_rdy;

   // row of multiply-accumulate cells, least significant byte of x first
   for (genvar k = 0; k < NC; k++) begin : g_cell
      qre_cell #(.DIGIT_POS(k)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (cell_v[k]),
         .up_lane    (cell_lane[k]),
         .up_ready   (cell_rdy[k]),
         .down_valid (cell_v[k+1]),
         .down_lane  (cell_lane[k+1]),
         .down_ready (cell_rdy[k+1])
      );
   end

   // scale back, clamp, register the result
   logic signed [AW-1:0] y_full;
   logic                 y_fits;
   logic [W-1:0]         y_sat;
   logic [W-1:0]         y_ff, root_ff;
   logic                 ovf_ff;
   logic [1:0]           kind_ff;

   assign y_full = $signed(cell_lane[NC].acc) >>> (2*FRAC_BITS);
   assign y_fits = (&y_full[AW-1:W-1]) || !(|y_full[AW-1:W-1]);
   assign y_sat  = y_fits ? y_full[W-1:0]
                 : (y_full[AW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_rdy) begin
         out_v_ff <= cell_v[NC];
      end
      if (out_rdy && cell_v[NC]) begin
         y_ff    <= y_sat;
         ovf_ff  <= !y_fits;
         kind_ff <= root_status.kind;
         root_ff <= root_status.root;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {{(qre_pkg::RSP_W-2*W-3){1'b0}}, root_ff, kind_ff, ovf_ff, y_ff};
endmodule

[rtl/qre_checker.sv]
// Port-level checks for quadratic_root_and_evaluate_top, bound to it below.
// Depends on qre_pkg.
module qre_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [qre_pkg::RSP_W-1:0]     rsp_tdata,
   input logic                          csr_wr_en,
   input logic [qre_pkg::CSR_IDX_W-1:0] csr_index
);
   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result transfer holds its data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // a coefficient write stops input while roots are recomputed
   assert property (@(posedge clock) disable iff (reset)
      csr_wr_en && (csr_index == qre_pkg::CSR_COEF_A || csr_index == qre_pkg::CSR_COEF_B ||
                    csr_index == qre_pkg::CSR_COEF_C) |=> !req_tready)
      else $error("input taken during root update");

   // no root reported when there is none or a is zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[34:33] == qre_pkg::KIND_NONE ||
                     rsp_tdata[34:33] == qre_pkg::KIND_DEGEN) |-> rsp_tdata[66:35] == '0)
      else $error("root reported without real root");

   // pad bits stay zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[qre_pkg::RSP_W-1:67] == '0)
      else $error("pad bits set");
endmodule

bind quadratic_root_and_evaluate_top qre_checker u_qre_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_wr_en  (csr_wr_en),
   .csr_index  (csr_index)
);

[tb/quadratic_root_and_evaluate_checker.sv]
`timescale 1ns / 100ps
// Result checker for quadratic_root_and_evaluate_top: watches the x, result
// and coefficient ports and predicts every result. Depends on qre_pkg.
module quadratic_root_and_evaluate_checker #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [qre_pkg::REQ_W-1:0]     req_tdata,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [qre_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                          csr_wr_en,
   input  logic [qre_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [qre_pkg::WORD_W-1:0]    csr_wdata,
   output int                            fail_count,
   output int                            results_owed,
   output int                            results_seen,
   output int                            kinds_seen [4]
);
   typedef logic signed [127:0] wide_type;

   // laid out as on rsp_tdata, lowest field last
   typedef struct packed {
      logic [31:0] root;
      logic [1:0]  kind;
      logic        ovf;
      logic [31:0] y;
   } quad_result_type;

   logic signed [31:0] coef_a, coef_b, coef_c;
   quad_result_type    owed_q[$];

   function automatic logic [31:0] clamp32(input wide_type v, output logic clipped);
      clipped = 1'b1;
      if (v > wide_type'(32'sh7FFF_FFFF)) return 32'h7FFF_FFFF;
      if (v < -wide_type'(64'sh8000_0000)) return 32'h8000_0000;
      clipped = 1'b0;
      return v[31:0];
   endfunction

   // floor square root; radicand stays well below 2^126
   function automatic wide_type floor_sqrt(input wide_type n);
      wide_type r, t;
      r = 0;
      for (int bitpos = 62; bitpos >= 0; bitpos--) begin
         t = r | (wide_type'(1) <<< bitpos);
         if (t * t <= n) r = t;
      end
      return r;
   endfunction

   function automatic quad_result_type evaluate(input logic signed [31:0] xv);
      quad_result_type res;
      wide_type aw, bw, cw, xw, acc, disc, s, num, am, nm, q;
      logic unused;
      aw = coef_a;
      bw = coef_b;
      cw = coef_c;
      xw = xv;
      acc = aw * xw * xw + ((bw * xw) <<< FRAC_BITS) + (cw <<< (2 * FRAC_BITS))
            + (wide_type'(1) <<< (2 * FRAC_BITS - 1));
      res.y = clamp32(acc >>> (2 * FRAC_BITS), res.ovf);
      disc = bw * bw - ((aw * cw) <<< 2);
      res.root = '0;
      if (aw == 0) begin
         res.kind = qre_pkg::KIND_DEGEN;
      end else if (disc < 0) begin
         res.kind = qre_pkg::KIND_NONE;
      end else begin
         res.kind = (disc == 0) ? qre_pkg::KIND_ONE : qre_pkg::KIND_TWO;
         s = (disc == 0) ? wide_type'(0) : floor_sqrt(disc <<< (2 * FRAC_BITS));
         // sign of the root term follows a, which picks the larger root
         num = -(bw <<< FRAC_BITS) + ((aw > 0) ? s : -s);
         am = (aw < 0) ? -aw : aw;
         nm = (num < 0) ? -num : num;
         q = (nm + am) / (2 * am);   // half away from zero
         if ((num < 0) != (aw < 0)) q = -q;
         res.root = clamp32(q, unused);
      end
      return res;
   endfunction

   always @(posedge clock) begin
      quad_result_type got, want;
      if (reset) begin
         coef_a <= '0;
         coef_b <= '0;
         coef_c <= '0;
         fail_count <= 0;
         results_seen <= 0;
         results_owed <= 0;
         owed_q.delete();
         for (int k = 0; k < 4; k++) kinds_seen[k] <= 0;
      end else begin
         if (req_tvalid && req_tready) owed_q.push_back(evaluate(req_tdata[31:0]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[66:0];
            results_seen <= results_seen + 1;
            kinds_seen[got.kind] <= kinds_seen[got.kind] + 1;
            if (owed_q.size() == 0) begin
               $error("result transfer with nothing expected: %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = owed_q.pop_front();
               if (got != want || rsp_tdata[qre_pkg::RSP_W-1:67] != '0) begin
                  fail_count <= fail_count + 1;
                  if (got.y != want.y)
                     $error("y_value expected %h actual %h", want.y, got.y);
                  if (got.ovf != want.ovf)
                     $error("y_overflow expected %b actual %b", want.ovf, got.ovf);
                  if (got.kind != want.kind)
                     $error("root_kind expected %0d actual %0d", want.kind, got.kind);
                  if (got.root != want.root)
                     $error("largest_root expected %h actual %h", want.root, got.root);
                  if (rsp_tdata[qre_pkg::RSP_W-1:67] != '0)
                     $error("tdata padding expected 0 actual %h",
                            rsp_tdata[qre_pkg::RSP_W-1:67]);
               end
            end
         end
         results_owed <= owed_q.size();
         if (csr_wr_en) begin
            case (csr_index)
               qre_pkg::CSR_COEF_A: coef_a <= csr_wdata;
               qre_pkg::CSR_COEF_B: coef_b <= csr_wdata;
               qre_pkg::CSR_COEF_C: coef_c <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

[tb/tb_quadratic_root_and_evaluate_top.sv]
`timescale 1ns / 100ps
// Top of the quadratic evaluate / root testbench: clock, reset, x stimulus,
// coefficient phases and verdict. Depends on qre_pkg, the DUT and the checker.
module tb_quadratic_root_and_evaluate_top;

   localparam int FRAC_BITS = 16;
   localparam logic [31:0] ONE  = 32'h0001_0000;
   localparam logic [31:0] HALF = 32'h0000_8000;
   localparam logic [31:0] MAXW = 32'h7FFF_FFFF;
   localparam logic [31:0] MINW = 32'h8000_0000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [qre_pkg::REQ_W-1:0]     req_tdata = '0;    // [31:0] x_value
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [qre_pkg::RSP_W-1:0]     rsp_tdata;  // [31:0] y, [32] ovf, [34:33] kind, [66:35] root
   logic                          csr_wr_en = 1'b0;
   logic [qre_pkg::CSR_IDX_W-1:0] csr_index = qre_pkg::CSR_COEF_A;
   logic [qre_pkg::WORD_W-1:0]    csr_wdata = '0;

   int  fail_count, results_owed, results_seen;
   int  kinds_seen [4];
   bit  steady_flow = 1'b0;   // no idling on either side while set
   int  x_sent = 0;
   int  phases_run = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   quadratic_root_and_evaluate_top #(.FRAC_BITS(FRAC_BITS)) dut (.*);

   quadratic_root_and_evaluate_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (.*);

   // result side back-pressure: ready low about a third of the time
   always @(posedge clock)
      rsp_tready <= steady_flow || ($urandom_range(99) >= 32);

   // One x transfer; ready settles after the edge, so it is sampled at the
   // falling edge. Valid stays up after the transfer until the next call or
   // a coefficient load drops it.
   task automatic push_x(input logic [31:0] xv);
      while (!steady_flow && $urandom_range(99) < 32) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= xv;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      x_sent++;
   endtask

   // Coefficients change only with the pipeline drained
   task automatic load_coefs(input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= qre_pkg::CSR_COEF_A;
      csr_wdata <= a;
      @(posedge clock);
      csr_index <= qre_pkg::CSR_COEF_B;
      csr_wdata <= b;
      @(posedge clock);
      csr_index <= qre_pkg::CSR_COEF_C;
      csr_wdata <= c;
      @(posedge clock);
      // out-of-range index must be ignored
      csr_index <= 2'd3;
      csr_wdata <= $urandom;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      phases_run++;
   endtask

   function automatic logic [31:0] rand_x();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2 * 655360)) - 655360);
         2: return 32'($signed($urandom_range(2 * 65536 * 300)) - 65536 * 300);
         default: return {16'($urandom_range(15)), 16'($urandom)};
      endcase
   endfunction

   function automatic logic [31:0] rand_coef();
      case ($urandom_range(2))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2 * 65536 * 16)) - 65536 * 16);
         default: return 32'($signed($urandom_range(2 * 4096)) - 4096);
      endcase
   endfunction

   task automatic directed_x();
      logic [31:0] pts [10] = '{32'h0, MAXW, MINW, ONE, -ONE, HALF, -HALF,
                                32'hFFFF_FFFF, 32'h0002_0000, 32'h5555_AAAA};
      foreach (pts[i]) push_x(pts[i]);
   endtask

   initial begin
      logic [31:0] k, m;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset coefficients: all zero, degenerate
      directed_x();
      // two roots at +/-2, one root at 1, none, degenerate with b set
      load_coefs(ONE, 32'h0, -(4 * ONE));
      directed_x();
      load_coefs(ONE, -(2 * ONE), ONE);
      push_x(ONE);
      push_x(32'h0);
      load_coefs(ONE, 32'h0, ONE);
      push_x(HALF);
      load_coefs(32'h0, 5 * ONE, ONE);
      push_x(3 * ONE);
      // extreme coefficients, both signs of a
      load_coefs(MAXW, MINW, MINW);
      directed_x();
      load_coefs(MINW, MAXW, MAXW);
      directed_x();
      load_coefs(-ONE, 32'h0, 9 * ONE);
      push_x(MAXW);

      for (int ph = 0; ph < 14; ph++) begin
         if (ph % 4 == 3) begin
            // double root at an integer point
            k = $urandom_range(1, 7);
            m = 32'($signed($urandom_range(20)) - 10);
            if ($urandom_range(1)) k = -k;
            load_coefs(k << 16, (-2 * k * m) << 16, (k * m * m) << 16);
         end else begin
            load_coefs(rand_coef(), rand_coef(), rand_coef());
         end
         steady_flow = (ph == 6);
         repeat (115) push_x(rand_x());
         steady_flow = 1'b0;
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d x transfers over %0d coefficient sets", x_sent, phases_run);
      $display("root classes none/one/two/degenerate: %0d/%0d/%0d/%0d",
               kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3]);
      if (fail_count == 0 && results_owed == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
